/* rtl/core/point_in_cylinder_classifier_macros.svh */
// Assertion macros shared by the point-in-cylinder classifier RTL.
`ifndef POINT_IN_CYLINDER_CLASSIFIER_MACROS_SVH
`define POINT_IN_CYLINDER_CLASSIFIER_MACROS_SVH

// Same-cycle implication, sampled on clk and switched off while arst_n is low.
`define PIC_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: same-cycle check failed");

// Next-cycle implication, sampled on clk and switched off while arst_n is low.
`define PIC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

/* rtl/core/pic_pkg.sv */
// Widths, register indexes and result codes of the point-in-cylinder classifier.
package pic_pkg;

	// Coordinate width of base centres and points.
	localparam int CW     = 16;
	// Difference of two coordinates.
	localparam int DW     = CW + 1;
	// Product of two differences.
	localparam int PW     = 2 * DW;
	// Sum of three products, signed.
	localparam int SW     = PW + 2;
	// Split point of the wide multiplier operands.
	localparam int H      = SW / 2;
	localparam int HW     = SW - H;
	// One partial product of the wide multiplier.
	localparam int PPW    = 2 * H + 2;
	// Full wide product.
	localparam int RW     = 2 * SW + 2;
	localparam int TOL_W  = 16;
	localparam int CFG_IW = 4;
	localparam int CFG_DW = 32;

	localparam logic [CFG_IW-1:0] REG_BASE1_X = CFG_IW'(0);
	localparam logic [CFG_IW-1:0] REG_BASE1_Y = CFG_IW'(1);
	localparam logic [CFG_IW-1:0] REG_BASE1_Z = CFG_IW'(2);
	localparam logic [CFG_IW-1:0] REG_BASE2_X = CFG_IW'(3);
	localparam logic [CFG_IW-1:0] REG_BASE2_Y = CFG_IW'(4);
	localparam logic [CFG_IW-1:0] REG_BASE2_Z = CFG_IW'(5);
	localparam logic [CFG_IW-1:0] REG_RADIUS  = CFG_IW'(6);
	localparam logic [CFG_IW-1:0] REG_TOL     = CFG_IW'(7);

	typedef enum logic [1:0] {
		LOC_INSIDE  = 2'd0,
		LOC_SURFACE = 2'd1,
		LOC_OUTSIDE = 2'd2
	} loc_t;

	// Load enables of the two stages inside the split multiplier.
	typedef struct packed {
		logic pp;
		logic sum;
	} mul_en_t;

endpackage

/* rtl/core/pic_split_mult.sv */
// Two-stage signed multiplier that splits each operand into halves.
module pic_split_mult (
	input  logic                           clk,
	input  pic_pkg::mul_en_t               en,
	input  logic signed [pic_pkg::SW-1:0]  x,
	input  logic signed [pic_pkg::SW-1:0]  y,
	output logic signed [pic_pkg::RW-1:0]  prod
);

	logic signed [pic_pkg::HW-1:0]  xh, yh;
	logic signed [pic_pkg::H:0]     xl, yl;
	logic signed [pic_pkg::PPW-1:0] pp_hh_s1, pp_hl_s1, pp_lh_s1, pp_ll_s1;
	logic signed [pic_pkg::RW-1:0]  prod_s2;

	// Low halves are unsigned, so they get a zero bit on top; high halves keep the sign.
	assign xh = x[pic_pkg::SW-1:pic_pkg::H];
	assign yh = y[pic_pkg::SW-1:pic_pkg::H];
	assign xl = {1'b0, x[pic_pkg::H-1:0]};
	assign yl = {1'b0, y[pic_pkg::H-1:0]};

	always_ff @(posedge clk) begin
		if (en.pp) begin
			pp_hh_s1 <= pic_pkg::PPW'(xh * yh);
			pp_hl_s1 <= pic_pkg::PPW'(xh * yl);
			pp_lh_s1 <= pic_pkg::PPW'(xl * yh);
			pp_ll_s1 <= pic_pkg::PPW'(xl * yl);
		end
	end

	always_ff @(posedge clk) begin
		if (en.sum) begin
			prod_s2 <= (pic_pkg::RW'(pp_hh_s1) <<< (2 * pic_pkg::H))
				+ (pic_pkg::RW'(pp_hl_s1) <<< pic_pkg::H)
				+ (pic_pkg::RW'(pp_lh_s1) <<< pic_pkg::H)
				+ pic_pkg::RW'(pp_ll_s1);
		end
	end

	assign prod = prod_s2;

endmodule

/* rtl/core/point_in_cylinder_classifier.sv */
// Top level of the point-in-cylinder classifier: configuration, pipeline and result register.
`include "point_in_cylinder_classifier_macros.svh"

// The block tells, for every streamed point, whether it lies inside, on the surface of, or
// outside a finite cylinder given by two base centres and a radius, all in exact integer
// arithmetic with no division. It takes one item per clock cycle while in_ready is high, and
// returns one result per item, in order. It passes through seven register stages: the
// coordinate differences, the nine coordinate products, the three dot-product sums, the
// partial products and the partial-product sums of the wide split multipliers, the surface
// difference, and the result register. Each stage loads whenever it is empty or the stage
// after it moves on, so a stalled result only holds back as many stages as are full behind
// it. A point exactly on the band edge counts as not on the surface. When the base centres
// coincide the result is outside with degenerate_axis set. Configuration writes are always
// taken and should only be made while no item is in flight; an index above seven is ignored.
module point_in_cylinder_classifier (
	input  logic                                 clk,
	input  logic                                 arst_n,

	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [pic_pkg::CFG_IW-1:0]           cfg_index,
	input  logic [pic_pkg::CFG_DW-1:0]           cfg_data,

	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [pic_pkg::CW-1:0]        point_x,
	input  logic signed [pic_pkg::CW-1:0]        point_y,
	input  logic signed [pic_pkg::CW-1:0]        point_z,

	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [1:0]                           location,
	output logic                                 degenerate_axis
);

	// Configuration registers.
	logic signed [pic_pkg::CW-1:0]    base1_q [3];
	logic signed [pic_pkg::CW-1:0]    base2_q [3];
	logic [pic_pkg::CW-2:0]           radius_q;
	logic [pic_pkg::TOL_W-1:0]        tol_q;

	// Stage valid bits and load enables.
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6, en_s7;

	// Pipeline payload.
	logic signed [pic_pkg::CW-1:0]    point [3];
	logic signed [pic_pkg::DW-1:0]    a_s1 [3];
	logic signed [pic_pkg::DW-1:0]    v_s1 [3];
	logic signed [pic_pkg::PW-1:0]    aa_s2 [3];
	logic signed [pic_pkg::PW-1:0]    av_s2 [3];
	logic signed [pic_pkg::PW-1:0]    vv_s2 [3];
	logic signed [pic_pkg::PW-1:0]    rr_s2;
	logic signed [pic_pkg::SW-1:0]    axis_sq_s3;
	logic signed [pic_pkg::SW-1:0]    proj_s3;
	logic signed [pic_pkg::SW-1:0]    lat_s3;
	logic signed [pic_pkg::SW-1:0]    tol_ext;
	logic                             deg_s4, outr_s4;
	logic                             deg_s5, outr_s5;
	logic signed [pic_pkg::RW-1:0]    axis_lat_s5;
	logic signed [pic_pkg::RW-1:0]    proj_sq_s5;
	logic signed [pic_pkg::RW-1:0]    band_s5;
	logic                             deg_s6, outr_s6;
	logic signed [pic_pkg::RW-1:0]    diff_s6;
	logic signed [pic_pkg::RW-1:0]    band_s6;
	logic signed [pic_pkg::RW-1:0]    band_neg_s6;
	pic_pkg::loc_t                    loc_s7;
	logic                             deg_s7;
	logic                             on_band;

	pic_pkg::mul_en_t                 mul_en;

	// The configuration port never stalls.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				base1_q[k] <= '0;
				base2_q[k] <= '0;
			end
			radius_q <= '0;
			tol_q    <= pic_pkg::TOL_W'(1);
		end else if (cfg_valid) begin
			case (cfg_index)
				pic_pkg::REG_BASE1_X: base1_q[0] <= cfg_data[pic_pkg::CW-1:0];
				pic_pkg::REG_BASE1_Y: base1_q[1] <= cfg_data[pic_pkg::CW-1:0];
				pic_pkg::REG_BASE1_Z: base1_q[2] <= cfg_data[pic_pkg::CW-1:0];
				pic_pkg::REG_BASE2_X: base2_q[0] <= cfg_data[pic_pkg::CW-1:0];
				pic_pkg::REG_BASE2_Y: base2_q[1] <= cfg_data[pic_pkg::CW-1:0];
				pic_pkg::REG_BASE2_Z: base2_q[2] <= cfg_data[pic_pkg::CW-1:0];
				pic_pkg::REG_RADIUS:  radius_q   <= cfg_data[pic_pkg::CW-2:0];
				pic_pkg::REG_TOL:     tol_q      <= cfg_data[pic_pkg::TOL_W-1:0];
				default: ;
			endcase
		end
	end

	// A stage loads when it is empty or its successor loads this cycle.
	assign en_s7 = !valid_s7 || out_ready;
	assign en_s6 = !valid_s6 || en_s7;
	assign en_s5 = !valid_s5 || en_s6;
	assign en_s4 = !valid_s4 || en_s5;
	assign en_s3 = !valid_s3 || en_s4;
	assign en_s2 = !valid_s2 || en_s3;
	assign en_s1 = !valid_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= in_valid;
			if (en_s2) valid_s2 <= valid_s1;
			if (en_s3) valid_s3 <= valid_s2;
			if (en_s4) valid_s4 <= valid_s3;
			if (en_s5) valid_s5 <= valid_s4;
			if (en_s6) valid_s6 <= valid_s5;
			if (en_s7) valid_s7 <= valid_s6;
		end
	end

	assign point[0] = point_x;
	assign point[1] = point_y;
	assign point[2] = point_z;

	// Stage 1: axis vector and point relative to the first base centre.
	always_ff @(posedge clk) begin
		if (en_s1) begin
			for (int k = 0; k < 3; k++) begin
				a_s1[k] <= pic_pkg::DW'(base2_q[k]) - pic_pkg::DW'(base1_q[k]);
				v_s1[k] <= pic_pkg::DW'(point[k]) - pic_pkg::DW'(base1_q[k]);
			end
		end
	end

	// Stage 2: per-axis products and the squared radius.
	always_ff @(posedge clk) begin
		if (en_s2) begin
			for (int k = 0; k < 3; k++) begin
				aa_s2[k] <= pic_pkg::PW'(a_s1[k] * a_s1[k]);
				av_s2[k] <= pic_pkg::PW'(a_s1[k] * v_s1[k]);
				vv_s2[k] <= pic_pkg::PW'(v_s1[k] * v_s1[k]);
			end
			rr_s2 <= pic_pkg::PW'(radius_q * radius_q);
		end
	end

	// Stage 3: squared axis length, projection, and squared distance less squared radius.
	always_ff @(posedge clk) begin
		if (en_s3) begin
			axis_sq_s3 <= pic_pkg::SW'(aa_s2[0]) + pic_pkg::SW'(aa_s2[1])
				+ pic_pkg::SW'(aa_s2[2]);
			proj_s3    <= pic_pkg::SW'(av_s2[0]) + pic_pkg::SW'(av_s2[1])
				+ pic_pkg::SW'(av_s2[2]);
			lat_s3     <= pic_pkg::SW'(vv_s2[0]) + pic_pkg::SW'(vv_s2[1])
				+ pic_pkg::SW'(vv_s2[2]) - pic_pkg::SW'(rr_s2);
		end
	end

	// Stages 4 and 5 are the partial-product and sum stages of the wide multipliers.
	assign mul_en.pp  = en_s4;
	assign mul_en.sum = en_s5;
	assign tol_ext    = pic_pkg::SW'(tol_q);

	pic_split_mult u_mul_axis_lat (
		.clk  (clk),
		.en   (mul_en),
		.x    (axis_sq_s3),
		.y    (lat_s3),
		.prod (axis_lat_s5)
	);

	pic_split_mult u_mul_proj_sq (
		.clk  (clk),
		.en   (mul_en),
		.x    (proj_s3),
		.y    (proj_s3),
		.prod (proj_sq_s5)
	);

	pic_split_mult u_mul_band (
		.clk  (clk),
		.en   (mul_en),
		.x    (tol_ext),
		.y    (axis_sq_s3),
		.prod (band_s5)
	);

	// The end-cap tests travel beside the multipliers.
	always_ff @(posedge clk) begin
		if (en_s4) begin
			deg_s4  <= (axis_sq_s3 == '0);
			outr_s4 <= (proj_s3 < 0) || (proj_s3 > axis_sq_s3);
		end
		if (en_s5) begin
			deg_s5  <= deg_s4;
			outr_s5 <= outr_s4;
		end
	end

	// Stage 6: scaled radial difference and the surface band on both sides of zero.
	always_ff @(posedge clk) begin
		if (en_s6) begin
			diff_s6     <= axis_lat_s5 - proj_sq_s5;
			band_s6     <= band_s5;
			band_neg_s6 <= -band_s5;
			deg_s6      <= deg_s5;
			outr_s6     <= outr_s5;
		end
	end

	// The point is on the surface when the difference lies strictly inside the band.
	assign on_band = (diff_s6 < band_s6) && (diff_s6 > band_neg_s6);

	// Stage 7: result register.
	always_ff @(posedge clk) begin
		if (en_s7) begin
			deg_s7 <= deg_s6;
			if (deg_s6 || outr_s6) begin
				loc_s7 <= pic_pkg::LOC_OUTSIDE;
			end else if (on_band) begin
				loc_s7 <= pic_pkg::LOC_SURFACE;
			end else if (diff_s6 < 0) begin
				loc_s7 <= pic_pkg::LOC_INSIDE;
			end else begin
				loc_s7 <= pic_pkg::LOC_OUTSIDE;
			end
		end
	end

	assign out_valid       = valid_s7;
	assign location        = loc_s7;
	assign degenerate_axis = deg_s7;

	// A degenerate axis always reports the point as outside.
	`PIC_ASSERT_IMPL(a_deg_outside, out_valid && degenerate_axis, location == pic_pkg::LOC_OUTSIDE)
	// With the result register empty, the whole pipeline can move, so an item is taken.
	`PIC_ASSERT_IMPL(a_empty_ready, !out_valid, in_ready)
	// An item leaving the last inner stage lands in the result register.
	`PIC_ASSERT_NEXT(a_s6_to_out, valid_s6 && en_s7, out_valid)

endmodule
